FILE: rtl/doubly_linked_list_with_cursor_top_macros.svh
// ----------------------------------------------------------------------------
// Linked list assertion macros
// Concurrent assertion shorthands used by the top level.
// ----------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_LIST_WITH_CURSOR_TOP_MACROS_SVH
`define DOUBLY_LINKED_LIST_WITH_CURSOR_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define DLL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define DLL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/dll_pkg.sv
// ----------------------------------------------------------------------------
// Linked list package
// Action codes, controller states and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dll_pkg;

   typedef enum logic [3:0] {
      ACT_CLEAR      = 4'd0,
      ACT_INS_FIRST  = 4'd1,
      ACT_INS_LAST   = 4'd2,
      ACT_CUR_FIRST  = 4'd3,
      ACT_CUR_LAST   = 4'd4,
      ACT_DEL_FIRST  = 4'd5,
      ACT_DEL_LAST   = 4'd6,
      ACT_DEL_AFTER  = 4'd7,
      ACT_DEL_BEFORE = 4'd8,
      ACT_INS_AFTER  = 4'd9,
      ACT_INS_BEFORE = 4'd10,
      ACT_OVERWRITE  = 4'd11,
      ACT_NEXT       = 4'd12,
      ACT_PREV       = 4'd13,
      ACT_NONE       = 4'd14,
      ACT_SPARE      = 4'd15
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_STEP2,
      ST_STEP3,
      ST_SHOW,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture request payload
      logic exec;    // first phase: read links, allocate, plan
      logic step2;   // second phase: neighbor read and link writes
      logic step3;   // third phase: further link writes
      logic show;    // issue reads of the shown values, remaining link writes
      logic capture; // capture result registers
   } cmd_type;

endpackage

FILE: rtl/dll_ctrl.sv
// ----------------------------------------------------------------------------
// Linked list controller
// Sequences the phases of one request and runs the two handshakes.
// ----------------------------------------------------------------------------
module dll_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dll_pkg::cmd_type cmd
);
   import dll_pkg::*;

   state_type state_ff, state_in;
   logic      full_ff, full_in;

   // State and result-held flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         full_ff  <= full_in;
      end
   end

   // Next state. A new request starts while an older result still waits,
   // but its result is captured only after the old one has left.
   always_comb begin
      state_in = state_ff;
      full_in  = full_ff;
      if (full_ff && rsp_ready) full_in = 1'b0;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_STEP2;
         ST_STEP2: state_in = ST_STEP3;
         ST_STEP3: state_in = ST_SHOW;
         ST_SHOW:  state_in = ST_RESP;
         ST_RESP: begin
            if (!full_ff || rsp_ready) begin
               full_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = full_ff;
      case (state_ff)
         ST_IDLE:  cmd.load  = req_valid;
         ST_EXEC:  cmd.exec  = 1'b1;
         ST_STEP2: cmd.step2 = 1'b1;
         ST_STEP3: cmd.step3 = 1'b1;
         ST_SHOW:  cmd.show  = 1'b1;
         ST_RESP:  cmd.capture = !full_ff || rsp_ready;
         default:  cmd = '0;
      endcase
   end

endmodule

FILE: rtl/dll_dp.sv
// ----------------------------------------------------------------------------
// Linked list datapath
// Node memories, list pointers, free pool and result registers.
// ----------------------------------------------------------------------------
module dll_dp #(
   parameter int NODE_COUNT = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  dll_pkg::cmd_type    cmd,
   input  logic [3:0]          req_action,
   input  logic signed [31:0]  req_value,
   output logic signed [31:0]  rsp_first_value,
   output logic signed [31:0]  rsp_last_value,
   output logic signed [31:0]  rsp_cursor_value,
   output logic                rsp_list_nonempty,
   output logic                rsp_cursor_valid,
   output logic                rsp_alloc_error
);
   import dll_pkg::*;

   localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int CW = $clog2(NODE_COUNT + 1);
   localparam logic [CW-1:0] FULL = CW'(NODE_COUNT);

   // Memories: data, next and prev links.
   logic [VALUE_BITS-1:0] mem_data [NODE_COUNT];
   logic [IW-1:0]         mem_next [NODE_COUNT];
   logic [IW-1:0]         mem_prev [NODE_COUNT];

   // Payload and list state.
   action_type            act_ff;
   logic [VALUE_BITS-1:0] word_ff;
   logic [IW-1:0] first_ff, last_ff, cur_ff, head_ff, node_ff, tgt_ff;
   logic          ne_ff, cv_ff, err_ff, ok_ff;
   logic [CW-1:0] fcnt_ff, fresh_ff;
   // Link read registers (next/prev of a read address).
   logic [IW-1:0] rn_ff, rp_ff;
   logic [VALUE_BITS-1:0] d0_ff, d1_ff, d2_ff;
   // High during step2 when the insert took its node from the free stack.
   logic          pop_ff;

   // Single next/prev write port per phase.
   logic          wn_en, wp_en, wd_en;
   logic [IW-1:0] wn_addr, wn_data, wp_addr, wp_data, wd_addr, rd_addr;
   logic          rd_en;

   // The cursor value is final after step2, first and last after step3,
   // so the shown words are read over two phases, at most two per cycle.
   always_ff @(posedge clock) begin
      if (wn_en) mem_next[wn_addr] <= wn_data;
      if (wp_en) mem_prev[wp_addr] <= wp_data;
      if (wd_en) mem_data[wd_addr] <= word_ff;
      if (rd_en) begin
         rn_ff <= mem_next[rd_addr];
         rp_ff <= mem_prev[rd_addr];
      end
      if (cmd.step3) d2_ff <= mem_data[cur_ff];
      if (cmd.show) begin
         d0_ff <= mem_data[first_ff];
         d1_ff <= mem_data[last_ff];
      end
   end

   function automatic logic [31:0] sx(input logic [VALUE_BITS-1:0] v);
      logic [VALUE_BITS+31:0] e;
      e = {{32{v[VALUE_BITS-1]}}, v};
      return e[31:0];
   endfunction

   logic has_fresh, has_free, is_ins;
   always_comb begin
      has_free  = fcnt_ff != '0;
      has_fresh = fresh_ff < FULL;
      is_ins = (act_ff == ACT_INS_FIRST) || (act_ff == ACT_INS_LAST) ||
               ((act_ff == ACT_INS_AFTER || act_ff == ACT_INS_BEFORE) && cv_ff);
   end

   // Read address per phase: exec reads free head, first/last or cursor links,
   // step2 reads the neighbor links.
   always_comb begin
      rd_en = cmd.exec || cmd.step2;
      rd_addr = cur_ff;
      if (cmd.exec) begin
         case (act_ff)
            ACT_INS_FIRST, ACT_INS_LAST, ACT_INS_AFTER, ACT_INS_BEFORE:
               rd_addr = head_ff;
            ACT_DEL_FIRST: rd_addr = first_ff;
            ACT_DEL_LAST:  rd_addr = last_ff;
            default:       rd_addr = cur_ff;
         endcase
      end else begin
         // step2: cursor links for cursor ops, target links for deletes
         case (act_ff)
            ACT_DEL_AFTER:  rd_addr = rn_ff;
            ACT_DEL_BEFORE: rd_addr = rp_ff;
            default:        rd_addr = cur_ff;
         endcase
      end
   end

   // Memory writes by phase.
   always_comb begin
      wn_en = 1'b0; wp_en = 1'b0; wd_en = 1'b0;
      wn_addr = node_ff; wn_data = node_ff;
      wp_addr = node_ff; wp_data = node_ff;
      wd_addr = node_ff;
      if (cmd.step2 && ok_ff) begin
         case (act_ff)
            ACT_INS_FIRST: begin
               // New node points at the old first; old first points back.
               wd_en = 1'b1; wn_en = 1'b1; wp_en = 1'b1;
               wn_data = ne_ff ? first_ff : node_ff;
               wp_addr = ne_ff ? first_ff : node_ff;
            end
            ACT_INS_LAST: begin
               wd_en = 1'b1; wn_en = 1'b1; wp_en = 1'b1;
               wp_data = ne_ff ? last_ff : node_ff;
               wn_addr = ne_ff ? last_ff : node_ff;
            end
            ACT_DEL_FIRST, ACT_DEL_LAST: begin
               wn_en = 1'b1; wn_data = head_ff;
               wn_addr = (act_ff == ACT_DEL_FIRST) ? first_ff : last_ff;
            end
            ACT_OVERWRITE: begin
               wd_en = 1'b1; wd_addr = cur_ff;
            end
            default: ;
         endcase
      end else if (cmd.step3 && ok_ff) begin
         case (act_ff)
            ACT_INS_FIRST: begin
               wp_en = 1'b1;
            end
            ACT_INS_LAST: begin
               wn_en = 1'b1;
            end
            ACT_INS_AFTER: begin
               // rn_ff = old cursor next
               wd_en = 1'b1;
               wn_en = 1'b1; wn_addr = node_ff; wn_data = rn_ff;
               wp_en = 1'b1; wp_addr = node_ff; wp_data = cur_ff;
            end
            ACT_INS_BEFORE: begin
               wd_en = 1'b1;
               wn_en = 1'b1; wn_addr = node_ff; wn_data = cur_ff;
               wp_en = 1'b1; wp_addr = node_ff; wp_data = rp_ff;
            end
            ACT_DEL_AFTER: begin
               // rn_ff = target next; relink cursor around the target
               wn_en = 1'b1; wn_addr = cur_ff; wn_data = rn_ff;
               wp_en = (tgt_ff != last_ff); wp_addr = rn_ff; wp_data = cur_ff;
            end
            ACT_DEL_BEFORE: begin
               wp_en = 1'b1; wp_addr = cur_ff; wp_data = rp_ff;
               wn_en = (tgt_ff != first_ff); wn_addr = rp_ff; wn_data = cur_ff;
            end
            default: ;
         endcase
      end else if (cmd.show && ok_ff) begin
         // Fourth phase: remaining link fix-ups.
         case (act_ff)
            ACT_INS_AFTER: begin
               wn_en = 1'b1; wn_addr = cur_ff; wn_data = node_ff;
               wp_en = (last_ff != node_ff);
               wp_addr = tgt_ff; wp_data = node_ff;
            end
            ACT_INS_BEFORE: begin
               wp_en = 1'b1; wp_addr = cur_ff; wp_data = node_ff;
               wn_en = (first_ff != node_ff);
               wn_addr = tgt_ff; wn_data = node_ff;
            end
            ACT_DEL_AFTER, ACT_DEL_BEFORE: begin
               wn_en = 1'b1; wn_addr = tgt_ff; wn_data = head_ff;
            end
            default: ;
         endcase
      end
   end

   // List state updates.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= action_type'(req_action);
         word_ff <= VALUE_BITS'({{32{req_value[31]}}, req_value});
      end
      if (reset) begin
         first_ff <= '0; last_ff <= '0; cur_ff <= '0; head_ff <= '0;
         ne_ff <= 1'b0; cv_ff <= 1'b0; err_ff <= 1'b0; ok_ff <= 1'b0;
         fcnt_ff <= '0; fresh_ff <= '0;
      end else if (cmd.load) begin
         err_ff <= 1'b0;
         ok_ff  <= 1'b0;
      end else if (cmd.exec) begin
         // Allocation for inserts; plan for others.
         if (act_ff == ACT_CLEAR) begin
            first_ff <= '0; last_ff <= '0; cur_ff <= '0;
            ne_ff <= 1'b0; cv_ff <= 1'b0;
            head_ff <= '0; fcnt_ff <= '0; fresh_ff <= '0;
         end else if (is_ins) begin
            if (has_free) begin
               node_ff <= head_ff; ok_ff <= 1'b1; fcnt_ff <= fcnt_ff - CW'(1);
            end else if (has_fresh) begin
               node_ff <= fresh_ff[IW-1:0]; ok_ff <= 1'b1;
               fresh_ff <= fresh_ff + CW'(1);
            end else begin
               err_ff <= 1'b1;
            end
         end else begin
            case (act_ff)
               ACT_CUR_FIRST: begin cv_ff <= ne_ff; cur_ff <= first_ff; end
               ACT_CUR_LAST:  begin cv_ff <= ne_ff; cur_ff <= last_ff;  end
               ACT_DEL_FIRST, ACT_DEL_LAST: ok_ff <= ne_ff;
               ACT_DEL_AFTER:  ok_ff <= cv_ff && (cur_ff != last_ff);
               ACT_DEL_BEFORE: ok_ff <= cv_ff && (cur_ff != first_ff);
               ACT_OVERWRITE, ACT_NEXT, ACT_PREV: ok_ff <= cv_ff;
               default: ;
            endcase
         end
      end else if (cmd.step2) begin
         // rn/rp now hold links of the exec read address; a popped node's
         // next link is the new free-stack head.
         if (pop_ff) head_ff <= rn_ff;
         if (ok_ff) begin
            case (act_ff)
               ACT_INS_FIRST, ACT_INS_LAST: begin
                  if (!ne_ff) begin
                     first_ff <= node_ff; last_ff <= node_ff; ne_ff <= 1'b1;
                  end else if (act_ff == ACT_INS_FIRST) first_ff <= node_ff;
                  else last_ff <= node_ff;
               end
               ACT_DEL_FIRST, ACT_DEL_LAST: begin
                  node_ff <= (act_ff == ACT_DEL_FIRST) ? first_ff : last_ff;
                  if (cv_ff && cur_ff == ((act_ff == ACT_DEL_FIRST) ?
                                          first_ff : last_ff)) cv_ff <= 1'b0;
                  if (first_ff == last_ff) ne_ff <= 1'b0;
                  else if (act_ff == ACT_DEL_FIRST) first_ff <= rn_ff;
                  else last_ff <= rp_ff;
                  head_ff <= (act_ff == ACT_DEL_FIRST) ? first_ff : last_ff;
                  fcnt_ff <= fcnt_ff + CW'(1);
               end
               ACT_DEL_AFTER:  tgt_ff <= rn_ff;
               ACT_DEL_BEFORE: tgt_ff <= rp_ff;
               ACT_NEXT: begin
                  if (cur_ff == last_ff) cv_ff <= 1'b0; else cur_ff <= rn_ff;
               end
               ACT_PREV: begin
                  if (cur_ff == first_ff) cv_ff <= 1'b0; else cur_ff <= rp_ff;
               end
               default: ;
            endcase
         end
      end else if (cmd.step3) begin
         if (ok_ff) begin
            case (act_ff)
               ACT_INS_AFTER: begin
                  tgt_ff <= rn_ff;
                  if (last_ff == cur_ff) last_ff <= node_ff;
               end
               ACT_INS_BEFORE: begin
                  tgt_ff <= rp_ff;
                  if (first_ff == cur_ff) first_ff <= node_ff;
               end
               ACT_DEL_AFTER: begin
                  if (tgt_ff == last_ff) last_ff <= cur_ff;
               end
               ACT_DEL_BEFORE: begin
                  if (tgt_ff == first_ff) first_ff <= cur_ff;
               end
               default: ;
            endcase
         end
      end else if (cmd.show) begin
         if (ok_ff) begin
            case (act_ff)
               ACT_DEL_AFTER, ACT_DEL_BEFORE: begin
                  head_ff <= tgt_ff; fcnt_ff <= fcnt_ff + CW'(1);
               end
               default: ;
            endcase
         end
      end
   end

   // Marks an insert that pops the free stack; the head advances in step2.
   always_ff @(posedge clock) begin
      if (reset) pop_ff <= 1'b0;
      else pop_ff <= cmd.exec && is_ins && has_free;
   end

   // Results.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rsp_first_value   <= ne_ff ? sx(d0_ff) : '0;
         rsp_last_value    <= ne_ff ? sx(d1_ff) : '0;
         rsp_cursor_value  <= cv_ff ? sx(d2_ff) : '0;
         rsp_list_nonempty <= ne_ff;
         rsp_cursor_valid  <= cv_ff;
         rsp_alloc_error   <= err_ff;
      end
   end
endmodule

FILE: rtl/doubly_linked_list_with_cursor_top.sv
// ----------------------------------------------------------------------------
// Doubly linked list with cursor
// Node pool list engine with first, last and cursor pointers.
// ----------------------------------------------------------------------------
// Usage: the request channel (req_valid/req_ready) carries one action code
// and a data word. Each request yields exactly one response on the rsp_
// channel with the first, last and cursor values, their validity flags and
// an allocation error flag for inserts into a full pool.
// Sequence: after a request is accepted, the link memory phases run in order
// (allocate and read cursor links, read neighbor links, write links, read
// shown values) and the response is then captured.
// A finished response is held in an output register; the next request is
// accepted while it waits, and its result waits until the old one leaves.
// Reset: synchronous, active high; the list is empty, no cursor, pool
// fully unused. Node memories are not cleared.
// ----------------------------------------------------------------------------
`include "doubly_linked_list_with_cursor_top_macros.svh"
module doubly_linked_list_with_cursor_top #(
   parameter int NODE_COUNT = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_action,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_first_value,
   output logic signed [31:0] rsp_last_value,
   output logic signed [31:0] rsp_cursor_value,
   output logic               rsp_list_nonempty,
   output logic               rsp_cursor_valid,
   output logic               rsp_alloc_error
);
   import dll_pkg::*;

   cmd_type cmd;

   // Controller.
   dll_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_ready(req_ready), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd)
   );

   // Datapath.
   dll_dp #(.NODE_COUNT(NODE_COUNT), .VALUE_BITS(VALUE_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_action(req_action),
      .req_value(req_value), .rsp_first_value(rsp_first_value),
      .rsp_last_value(rsp_last_value), .rsp_cursor_value(rsp_cursor_value),
      .rsp_list_nonempty(rsp_list_nonempty),
      .rsp_cursor_valid(rsp_cursor_valid), .rsp_alloc_error(rsp_alloc_error)
   );

   // Checks.
   `DLL_ASSERT_IMP(a_cursor_needs_list, clock, reset,
      rsp_valid && rsp_cursor_valid, rsp_list_nonempty, "cursor on empty list")
   `DLL_ASSERT_NXT(a_one_phase, clock, reset, cmd.load,
      $onehot0({cmd.exec, cmd.step2, cmd.step3, cmd.show}) && cmd.exec,
      "phase sequence broken")
   `DLL_ASSERT_IMP(a_no_accept_busy, clock, reset,
      req_ready, !(cmd.exec || cmd.step2 || cmd.step3 || cmd.show),
      "request taken while busy")
endmodule
